// ===== rtl/bof_pkg.sv =====
// Package with the shared constants, types and state codes of the box overlap fraction block.
package bof_pkg;

  localparam int CoordWidth = 32;
  localparam int FracBits   = 16;
  localparam int CntW       = $clog2(FracBits);
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic [FracBits:0] One = {1'b1, {FracBits{1'b0}}};

  typedef struct packed {
    logic                  empty;
    logic                  last;
    logic [CoordWidth-1:0] inter_width;
    logic [CoordWidth-1:0] first_width;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_EMIT
  } back_state_e;

endpackage

// ===== rtl/bof_if.sv =====
// Request and result channel interfaces of the box overlap fraction block.
interface bof_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [bof_pkg::CoordWidth-1:0] first_lower;
  logic signed [bof_pkg::CoordWidth-1:0] first_upper;
  logic signed [bof_pkg::CoordWidth-1:0] second_lower;
  logic signed [bof_pkg::CoordWidth-1:0] second_upper;
  logic                                  last_dimension;

  modport source(output valid, first_lower, first_upper, second_lower, second_upper,
                 last_dimension, input ready);
  modport sink(input valid, first_lower, first_upper, second_lower, second_upper,
               last_dimension, output ready);
endinterface

interface bof_out_if;
  logic                          valid;
  logic                          ready;
  logic [bof_pkg::FracBits:0]    fraction;
  logic                          disjoint;

  modport source(output valid, fraction, disjoint, input ready);
  modport sink(input valid, fraction, disjoint, output ready);
endinterface

// ===== rtl/bof_front.sv =====
// Front part: intersects the two intervals of a request and classifies it into a job.
module bof_front (
  bof_in_if.sink             in_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output bof_pkg::job_t      push_job_o
);

  logic signed [bof_pkg::CoordWidth-1:0] lo;
  logic signed [bof_pkg::CoordWidth-1:0] hi;

  always_comb begin
    lo = (in_i.first_lower > in_i.second_lower) ? in_i.first_lower : in_i.second_lower;
    hi = (in_i.first_upper < in_i.second_upper) ? in_i.first_upper : in_i.second_upper;
    push_job_o.empty       = lo > hi;
    push_job_o.last        = in_i.last_dimension;
    push_job_o.inter_width = hi - lo;
    push_job_o.first_width = in_i.first_upper - in_i.first_lower;
  end

  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;

endmodule

// ===== rtl/bof_queue.sv =====
// Two-entry job queue between the front and the back part.
module bof_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  bof_pkg::job_t       push_job_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output bof_pkg::job_t       pop_job_o
);

  bof_pkg::job_t                   mem_q [bof_pkg::QueueDepth];
  logic [bof_pkg::QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [bof_pkg::QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [bof_pkg::QCntW-1:0]       count_q, count_d;
  logic                            push, pop;

  assign push_ready_o = count_q != bof_pkg::QCntW'(bof_pkg::QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ===== rtl/bof_back.sv =====
// Back part: serial width divider, product accumulator and result register.
module bof_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  bof_pkg::job_t       pop_job_i,
  bof_out_if.source           out_o
);

  bof_pkg::back_state_e              state_q, state_d;
  logic [bof_pkg::CoordWidth-1:0]    rem_q, rem_d;
  logic [bof_pkg::CoordWidth-1:0]    den_q, den_d;
  logic [bof_pkg::FracBits-1:0]      quo_q, quo_d;
  logic [bof_pkg::CntW-1:0]          cnt_q, cnt_d;
  logic                              last_q, last_d;
  logic [bof_pkg::FracBits:0]        prod_q, prod_d;
  logic                              empty_q, empty_d;
  logic                              out_valid_q, out_valid_d;
  logic [bof_pkg::FracBits:0]        fraction_q, fraction_d;
  logic                              disjoint_q, disjoint_d;
  logic [bof_pkg::CoordWidth:0]      rem_shift;
  logic                              rem_ge;
  logic [bof_pkg::CoordWidth:0]      rem_sub;
  logic [2*bof_pkg::FracBits+1:0]    mul_full;

  assign rem_shift = {rem_q, 1'b0};
  assign rem_ge    = rem_shift >= {1'b0, den_q};
  assign rem_sub   = rem_shift - {1'b0, den_q};
  assign mul_full  = prod_q * {1'b0, quo_q};

  assign out_o.valid    = out_valid_q;
  assign out_o.fraction = fraction_q;
  assign out_o.disjoint = disjoint_q;

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    den_d       = den_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    prod_d      = prod_q;
    empty_d     = empty_q;
    fraction_d  = fraction_q;
    disjoint_d  = disjoint_q;
    out_valid_d = out_valid_q && !out_o.ready;
    pop_ready_o = 1'b0;
    case (state_q)
      bof_pkg::ST_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          last_d  = pop_job_i.last;
          empty_d = empty_q || pop_job_i.empty;
          if (!empty_d && pop_job_i.inter_width != pop_job_i.first_width) begin
            rem_d   = pop_job_i.inter_width;
            den_d   = pop_job_i.first_width;
            quo_d   = '0;
            cnt_d   = '0;
            state_d = bof_pkg::ST_DIV;
          end else if (pop_job_i.last) begin
            state_d = bof_pkg::ST_EMIT;
          end
        end
      end
      bof_pkg::ST_DIV: begin
        rem_d = rem_ge ? rem_sub[bof_pkg::CoordWidth-1:0]
                       : rem_shift[bof_pkg::CoordWidth-1:0];
        quo_d = {quo_q[bof_pkg::FracBits-2:0], rem_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == bof_pkg::CntW'(bof_pkg::FracBits - 1)) begin
          state_d = bof_pkg::ST_MUL;
        end
      end
      bof_pkg::ST_MUL: begin
        prod_d  = mul_full[2*bof_pkg::FracBits:bof_pkg::FracBits];
        state_d = last_q ? bof_pkg::ST_EMIT : bof_pkg::ST_IDLE;
      end
      bof_pkg::ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          fraction_d  = empty_q ? '0 : prod_q;
          disjoint_d  = empty_q;
          prod_d      = bof_pkg::One;
          empty_d     = 1'b0;
          state_d     = bof_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bof_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bof_pkg::ST_IDLE;
      prod_q      <= bof_pkg::One;
      empty_q     <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      prod_q      <= prod_d;
      empty_q     <= empty_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    den_q      <= den_d;
    quo_q      <= quo_d;
    fraction_q <= fraction_d;
    disjoint_q <= disjoint_d;
  end

  // The running product never exceeds one.
  a_prod_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prod_q <= bof_pkg::One)
    else $error("running product above one");

  // A disjoint result always carries a zero fraction.
  a_disjoint_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && disjoint_q |-> fraction_q == '0)
    else $error("disjoint result with nonzero fraction");

  // The partial remainder stays below the divisor throughout the division.
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bof_pkg::ST_DIV |-> rem_q < den_q)
    else $error("divider remainder not below divisor");

  // The last division step always hands over to the multiply step.
  a_div_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bof_pkg::ST_DIV && cnt_q == bof_pkg::CntW'(bof_pkg::FracBits - 1)
    |=> state_q == bof_pkg::ST_MUL)
    else $error("division did not end in the multiply step");

  // A pending result is held until it is taken.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q && $stable(fraction_q))
    else $error("pending result dropped or changed");

endmodule

// ===== rtl/box_overlap_fraction_core.sv =====
// Top level of the box overlap fraction block: front, job queue and back part.
// Each request carries one dimension of two boxes; on the request marked as the last
// dimension the block returns the part of the first box inside the second, unsigned
// Q1.16. A request whose interval ratio is not exactly one is taken in the idle state,
// runs through the serial restoring divider and then the multiply step; a request with
// an empty intersection, an already disjoint pair or equal widths is handled in the idle
// state alone, and the last dimension adds the emit state to load the result register.
// The divider sets the sustained rate; a two-entry queue lets the front take requests
// while the back part is busy and the result register waits to be taken.
module box_overlap_fraction_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  bof_in_if.sink      in_i,
  bof_out_if.source   out_o
);

  logic            push_valid;
  logic            push_ready;
  bof_pkg::job_t   push_job;
  logic            pop_valid;
  logic            pop_ready;
  bof_pkg::job_t   pop_job;

  bof_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  bof_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  bof_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_job_i   (pop_job),
    .out_o       (out_o)
  );

endmodule

// ===== sim/box_overlap_fraction_core_test.sv =====
// Self-checking testbench of box_overlap_fraction_core with directed and random box pairs.
`timescale 1ns / 1ps

module box_overlap_fraction_core_test;

  localparam int RandomRequests = 950;
  localparam int CalmAfter      = 800;
  localparam int SettleCycles   = 64;
  localparam int CycleLimit     = 300000;

  localparam logic signed [bof_pkg::CoordWidth-1:0] CoordMin =
    {1'b1, {(bof_pkg::CoordWidth-1){1'b0}}};
  localparam logic signed [bof_pkg::CoordWidth-1:0] CoordMax =
    {1'b0, {(bof_pkg::CoordWidth-1){1'b1}}};

  typedef struct packed {
    logic signed [bof_pkg::CoordWidth-1:0] first_lo;
    logic signed [bof_pkg::CoordWidth-1:0] first_hi;
    logic signed [bof_pkg::CoordWidth-1:0] second_lo;
    logic signed [bof_pkg::CoordWidth-1:0] second_hi;
    logic                                  last_dim;
    logic                                  typed;
    logic [bof_pkg::FracBits:0]            want_fraction;
    logic                                  want_disjoint;
  } box_dim_t;

  typedef struct packed {
    logic [bof_pkg::FracBits:0] fraction;
    logic                       disjoint;
  } overlap_result_t;

  localparam int DirectedRows = 21;

  box_dim_t directed_dims [DirectedRows] = '{
    '{0, 32'sh0001_0000, 0, 32'sh0001_0000, 1'b1, 1'b1, bof_pkg::One, 1'b0},
    '{0, 10, 20, 30, 1'b1, 1'b1, '0, 1'b1},
    '{100, 50, 0, 200, 1'b1, 1'b1, '0, 1'b1},
    '{5, 5, 0, 10, 1'b1, 1'b1, bof_pkg::One, 1'b0},
    '{0, 10, 10, 20, 1'b1, 1'b1, '0, 1'b0},
    '{CoordMin, CoordMax, CoordMin, CoordMax, 1'b1, 1'b1, bof_pkg::One, 1'b0},
    '{CoordMin, CoordMax, 0, CoordMax, 1'b1, 1'b0, '0, 1'b0},
    '{CoordMin, CoordMax, CoordMin, CoordMin, 1'b1, 1'b1, '0, 1'b0},
    '{CoordMax, CoordMax, CoordMin, CoordMax, 1'b1, 1'b1, bof_pkg::One, 1'b0},
    '{CoordMin, CoordMin, CoordMax, CoordMax, 1'b1, 1'b1, '0, 1'b1},
    '{0, 32'sh0002_0000, 32'sh0001_0000, 32'sh0003_0000, 1'b0, 1'b0, '0, 1'b0},
    '{0, 32'sh0002_0000, 32'sh0001_0000, 32'sh0003_0000, 1'b1, 1'b0, '0, 1'b0},
    '{0, 100, 50, 200, 1'b0, 1'b0, '0, 1'b0},
    '{0, 10, 20, 30, 1'b0, 1'b0, '0, 1'b0},
    '{0, 100, 0, 100, 1'b1, 1'b1, '0, 1'b1},
    '{0, 3, 1, 5, 1'b0, 1'b0, '0, 1'b0},
    '{0, 3, 1, 5, 1'b0, 1'b0, '0, 1'b0},
    '{0, 3, 1, 5, 1'b1, 1'b0, '0, 1'b0},
    '{-32'sh0003_0000, -32'sh0001_0000, -32'sh0002_0000, 32'sh0001_0000,
      1'b1, 1'b0, '0, 1'b0},
    '{32'shFFFF_FFFF, 32'sh7FFF_FFFF, 32'shFFFF_FFFE, 32'sh7FFF_FFFE,
      1'b1, 1'b0, '0, 1'b0},
    '{0, 1000, 250, 500, 1'b1, 1'b0, '0, 1'b0}
  };

  logic clk_i;
  logic rst_ni;

  bof_in_if  in_bus();
  bof_out_if out_bus();

  box_overlap_fraction_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  logic [bof_pkg::FracBits:0] overlap_product;
  logic                       pair_disjoint;
  overlap_result_t            expected_results[$];
  int                         mismatch_count;
  int                         cycle_count;
  int                         stall_left;
  bit                         calm;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic bit predict_overlap(input box_dim_t dim, output overlap_result_t res);
    logic signed [bof_pkg::CoordWidth-1:0] f_lo, f_hi, s_lo, s_hi, lo, hi;
    logic [bof_pkg::CoordWidth-1:0]        inter_w, first_w;
    logic [bof_pkg::FracBits:0]            ratio;
    logic [63:0]                           num;
    f_lo = dim.first_lo;
    f_hi = dim.first_hi;
    s_lo = dim.second_lo;
    s_hi = dim.second_hi;
    lo = (f_lo > s_lo) ? f_lo : s_lo;
    hi = (f_hi < s_hi) ? f_hi : s_hi;
    res = '0;
    if (lo > hi) begin
      pair_disjoint = 1'b1;
    end else begin
      inter_w = hi - lo;
      first_w = f_hi - f_lo;
      if (inter_w == first_w) begin
        ratio = bof_pkg::One;
      end else begin
        num   = 64'(inter_w) << bof_pkg::FracBits;
        ratio = (bof_pkg::FracBits+1)'(num / 64'(first_w));
      end
      overlap_product = (bof_pkg::FracBits+1)'(
        (64'(overlap_product) * 64'(ratio)) >> bof_pkg::FracBits);
    end
    if (!dim.last_dim) begin
      return 1'b0;
    end
    res.disjoint = pair_disjoint;
    res.fraction = pair_disjoint ? '0 : overlap_product;
    overlap_product = bof_pkg::One;
    pair_disjoint   = 1'b0;
    return 1'b1;
  endfunction

  function automatic box_dim_t random_dim(bit last);
    longint   a, b, c, d, w, lo1, hi1, lo2, hi2;
    box_dim_t dim;
    a = longint'(int'($urandom));
    b = longint'(int'($urandom));
    c = longint'(int'($urandom));
    d = longint'(int'($urandom));
    w = longint'($urandom_range(0, 1 << $urandom_range(0, 20)));
    dim = '0;
    dim.last_dim = last;
    case ($urandom_range(0, 9))
      0, 1: begin
        lo1 = (a < b) ? a : b;
        hi1 = (a < b) ? b : a;
        lo2 = (c < d) ? c : d;
        hi2 = (c < d) ? d : c;
      end
      7: begin
        lo1 = a >>> 1;
        hi1 = lo1 + w;
        lo2 = lo1 - longint'($urandom_range(0, 3));
        hi2 = hi1 + longint'($urandom_range(0, 3));
      end
      8: begin
        lo1 = a >>> 1;
        hi1 = lo1;
        lo2 = lo1 - w;
        hi2 = lo2 + 2 * w;
      end
      9: begin
        lo1 = a;
        hi1 = b;
        lo2 = c;
        hi2 = d;
        dim.last_dim = last | 1'($urandom_range(0, 1));
      end
      default: begin
        lo1 = a >>> 1;
        hi1 = lo1 + w;
        lo2 = lo1 - w - 10 + longint'($urandom_range(0, int'(2 * w + 20)));
        hi2 = lo2 + longint'($urandom_range(0, int'(2 * w + 20)));
      end
    endcase
    dim.first_lo  = bof_pkg::CoordWidth'(lo1);
    dim.first_hi  = bof_pkg::CoordWidth'(hi1);
    dim.second_lo = bof_pkg::CoordWidth'(lo2);
    dim.second_hi = bof_pkg::CoordWidth'(hi2);
    return dim;
  endfunction

  task automatic push_request(input box_dim_t dim);
    overlap_result_t res;
    in_bus.valid          <= 1'b1;
    in_bus.first_lower    <= dim.first_lo;
    in_bus.first_upper    <= dim.first_hi;
    in_bus.second_lower   <= dim.second_lo;
    in_bus.second_upper   <= dim.second_hi;
    in_bus.last_dimension <= dim.last_dim;
    do @(posedge clk_i); while (!in_bus.ready);
    if (predict_overlap(dim, res)) begin
      if (dim.typed) begin
        res.fraction = dim.want_fraction;
        res.disjoint = dim.want_disjoint;
      end
      expected_results.insert(expected_results.size(), res);
    end
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    overlap_result_t want;
    cycle_count <= cycle_count + 1;
    if (out_bus.valid && out_bus.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: fraction %0d, disjoint %0d",
               out_bus.fraction, out_bus.disjoint);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_bus.fraction !== want.fraction) begin
          $error("fraction: expected %0d, actual %0d", want.fraction, out_bus.fraction);
          mismatch_count++;
        end
        if (out_bus.disjoint !== want.disjoint) begin
          $error("disjoint: expected %0d, actual %0d", want.disjoint, out_bus.disjoint);
          mismatch_count++;
        end
      end
    end
    if (stall_left != 0) begin
      out_bus.ready <= 1'b0;
      stall_left--;
    end else if (!calm && rst_ni && $urandom_range(0, 9) == 0) begin
      out_bus.ready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_bus.ready <= rst_ni;
    end
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int sent;
    int dims;
    rst_ni                = 1'b0;
    in_bus.valid          = 1'b0;
    in_bus.first_lower    = '0;
    in_bus.first_upper    = '0;
    in_bus.second_lower   = '0;
    in_bus.second_upper   = '0;
    in_bus.last_dimension = 1'b0;
    out_bus.ready         = 1'b0;
    overlap_product       = bof_pkg::One;
    pair_disjoint         = 1'b0;
    mismatch_count        = 0;
    cycle_count           = 0;
    stall_left            = 0;
    calm                  = 1'b0;
    sent                  = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirectedRows; i++) begin
      push_request(directed_dims[i]);
    end

    while (sent < RandomRequests) begin
      dims = $urandom_range(1, 4);
      for (int k = 0; k < dims; k++) begin
        calm = (sent >= CalmAfter);
        push_request(random_dim(k == dims - 1));
        sent++;
      end
    end
    in_bus.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bof_pkg.sv
rtl/bof_if.sv
rtl/bof_front.sv
rtl/bof_queue.sv
rtl/bof_back.sv
rtl/box_overlap_fraction_core.sv
sim/box_overlap_fraction_core_test.sv
